// ===== rtl/assert_macros.svh =====
// assertion macros used by the queue engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define UMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ump assertion failed");
`define UMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ump assertion failed");
`else
`define UMP_ASSERT(lbl, prop)
`define UMP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/ump_pkg.sv =====
// types, codes and sizes of the unordered min priority queue
package ump_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OCC_W    = 5;
  localparam int ST_W     = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                    opcode;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] min_value;
    logic                    now_empty;
    logic [OCC_W-1:0]        occupancy;
  } out_item_t;

  // occupancy is the low bits of the count
  function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] c);
    logic [CNT_W+OCC_W-1:0] w;
    w = {{OCC_W{1'b0}}, c};
    return w[OCC_W-1:0];
  endfunction

endpackage

// ===== rtl/ump_ram.sv =====
// generic single write port ram with registered read
module ump_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ump_engine.sv =====
// queue sequencer: entry count, min scan and gap closing over the entry ram
`include "assert_macros.svh"
module ump_engine import ump_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              res_valid,
  input  logic              res_ready,
  output out_item_t         res_item,
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output logic [VAL_W-1:0]  ram_wdata,
  output logic [IDX_W-1:0]  ram_raddr,
  input  logic [VAL_W-1:0]  ram_rdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        cmp_r, cmp_nxt;
  logic [CNT_W-1:0]        src_r, src_nxt;
  logic [IDX_W-1:0]        best_r, best_nxt;
  logic signed [VAL_W-1:0] min_r, min_nxt;
  logic [ST_W-1:0]         status_r, status_nxt;

  logic signed [VAL_W-1:0] rd_val;
  logic                    take;
  logic [IDX_W-1:0]        best_new;
  logic signed [VAL_W-1:0] min_new;
  logic [CNT_W-1:0]        cmp_inc;
  logic [CNT_W-1:0]        best_inc;
  logic [CNT_W-1:0]        src_inc;
  logic [CNT_W-1:0]        src_dec;
  logic                    enq_full;

  // strict less-than keeps the earliest of equal minima
  assign rd_val   = signed'(ram_rdata);
  assign take     = (cmp_r == '0) || (rd_val < min_r);
  assign best_new = take ? cmp_r[IDX_W-1:0] : best_r;
  assign min_new  = take ? rd_val : min_r;
  assign cmp_inc  = cmp_r + CNT_W'(1);
  assign best_inc = CNT_W'(best_new) + CNT_W'(1);
  assign src_inc  = src_r + CNT_W'(1);
  assign src_dec  = src_r - CNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cmp_nxt    = cmp_r;
    src_nxt    = src_r;
    best_nxt   = best_r;
    min_nxt    = min_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = count_r[IDX_W-1:0];
    ram_wdata  = in_item.value;
    ram_raddr  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_item.opcode == OP_ENQ) begin
            min_nxt   = '0;
            state_nxt = S_DONE;
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
              status_nxt = ST_OK;
            end
          end else if (count_r == '0) begin
            min_nxt    = '0;
            status_nxt = ST_EMPTY;
            state_nxt  = S_DONE;
          end else begin
            ram_raddr = '0;
            cmp_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        min_nxt   = min_new;
        best_nxt  = best_new;
        cmp_nxt   = cmp_inc;
        ram_raddr = cmp_inc[IDX_W-1:0];
        if (cmp_inc == count_r) begin
          status_nxt = ST_OK;
          if (best_inc < count_r) begin
            // close the gap: read the entry after the minimum first
            ram_raddr = best_inc[IDX_W-1:0];
            src_nxt   = best_inc;
            state_nxt = S_SHIFT;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = src_dec[IDX_W-1:0];
        ram_wdata = ram_rdata;
        if (src_inc < count_r) begin
          ram_raddr = src_inc[IDX_W-1:0];
          src_nxt   = src_inc;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    cmp_r    <= cmp_nxt;
    src_r    <= src_nxt;
    best_r   <= best_nxt;
    min_r    <= min_nxt;
    status_r <= status_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign res_valid          = (state_r == S_DONE);
  assign res_item.status    = status_r;
  assign res_item.min_value = min_r;
  assign res_item.now_empty = (count_r == '0);
  assign res_item.occupancy = occ_of(count_r);

  assign enq_full = in_valid && in_ready && (in_item.opcode == OP_ENQ) &&
                    (count_r == CNT_W'(CAPACITY));

  `UMP_ASSERT(a_cnt_bound, count_r <= CNT_W'(CAPACITY))
  `UMP_ASSERT(a_shift_range, (state_r == S_SHIFT) |-> ((src_r < count_r) && (src_r != '0)))
  `UMP_ASSERT_NEXT(a_full_keeps, enq_full, $stable(count_r) && (status_r == ST_FULL))
  `UMP_ASSERT_NEXT(a_done_release, (state_r == S_DONE) && res_ready, state_r == S_IDLE)

endmodule

// ===== rtl/unordered_min_priority_queue_top.sv =====
// Unordered min priority queue of up to CAPACITY signed 32-bit values, kept in
// arrival order in a single synchronous ram. A dequeue of n stored entries reads
// the ram one entry a cycle to find the minimum (earliest of equal values), then
// moves each entry after it down by one, again one a cycle through the same ram.
// A refused item (dequeue on empty, enqueue on full) gets a result with status
// empty or full. Results sit in an output register, so the next item is taken
// while one waits.
module unordered_min_priority_queue_top import ump_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic              eng_in_ready;
  logic              res_valid;
  logic              res_ready;
  out_item_t         res_item;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  logic              out_valid_r;
  out_item_t         out_data_r;

  ump_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (eng_in_ready),
    .in_item   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ump_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output beat register
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_data_r <= res_item;
    end
  end

  assign in_stall  = !eng_in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/unordered_min_priority_queue_top_test.sv =====
// self-checking testbench of the unordered min priority queue, with random idling and stalls
`timescale 1ns / 1ps

module unordered_min_priority_queue_top_test;
  import ump_pkg::*;

  localparam int RUN_LIMIT    = 300000;
  localparam int SETTLE_TICKS = 2 * CAPACITY + 8;
  localparam int WALK_ITEMS   = 110;
  localparam int NUM_PHASES   = 4;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t                pending_items[$];
  out_item_t               expected_results[$];
  logic signed [VAL_W-1:0] held_values[$];
  out_item_t               want;
  int  planned_count  = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  in_beat        = 1'b0;

  int  phase_idle[NUM_PHASES]  = '{0, 83, 0, 30};
  int  phase_stall[NUM_PHASES] = '{0, 0, 83, 30};

  unordered_min_priority_queue_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // applies one beat to the shadow store and returns the result it should give
  function automatic out_item_t apply_queue_op(in_item_t beat);
    out_item_t res;
    int        best;
    int        idx;
    res = '0;
    if (beat.opcode == OP_ENQ) begin
      if (held_values.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        held_values.push_back(beat.value);
        res.status = ST_OK;
      end
    end else if (held_values.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // strict less-than keeps the earliest of equal minima
      best = 0;
      for (idx = 1; idx < held_values.size(); idx++) begin
        if (held_values[idx] < held_values[best]) best = idx;
      end
      res.min_value = held_values[best];
      held_values.delete(best);
      res.status = ST_OK;
    end
    res.now_empty = (held_values.size() == 0);
    res.occupancy = OCC_W'(held_values.size());
    return res;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(9))
      0:       v = {1'b1, {(VAL_W-1){1'b0}}};
      1:       v = {1'b0, {(VAL_W-1){1'b1}}};
      // narrow range so that equal minima turn up often
      2, 3:    v = VAL_W'(int'($urandom_range(8)) - 4);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic push_item(logic op, logic signed [VAL_W-1:0] val);
    in_item_t beat;
    beat.opcode = op;
    beat.value  = val;
    pending_items.push_back(beat);
    if (op == OP_ENQ && planned_count < CAPACITY) begin
      planned_count++;
    end else if (op == OP_DEQ && planned_count > 0) begin
      planned_count--;
    end
  endtask

  // sweeps the fill level up to full and back down to empty, with some noise
  task automatic queue_random_walk(int n);
    bit filling;
    int enq_pct;
    filling = 1'($urandom_range(1));
    repeat (n) begin
      if (filling && planned_count == CAPACITY && $urandom_range(2) == 0) begin
        filling = 1'b0;
      end else if (!filling && planned_count == 0 && $urandom_range(2) == 0) begin
        filling = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        enq_pct = 50;
      end else begin
        enq_pct = filling ? 80 : 20;
      end
      if ($urandom_range(99) < enq_pct) begin
        push_item(OP_ENQ, pick_value());
      end else begin
        push_item(OP_DEQ, $urandom);
      end
    end
  endtask

  // waits until every beat is in and every result is out
  task automatic wait_until_drained();
    while (!(pending_items.size() == 0 && !in_valid && expected_results.size() == 0)) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    in_beat = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: status %0d value %0d empty %0b occupancy %0d",
                 $time, out_data.status, out_data.min_value, out_data.now_empty,
                 out_data.occupancy);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status || out_data.min_value !== want.min_value ||
            out_data.now_empty !== want.now_empty || out_data.occupancy !== want.occupancy) begin
          mismatch_count++;
          $display(
            "%0t: mismatch st/val/empty/occ: expected %0d/%0d/%0b/%0d, got %0d/%0d/%0b/%0d",
            $time, want.status, want.min_value, want.now_empty, want.occupancy,
            out_data.status, out_data.min_value, out_data.now_empty,
            out_data.occupancy);
        end
      end
    end
    if (in_beat) expected_results.push_back(apply_queue_op(in_data));
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_beat) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int ph;
    int k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // dequeue on empty, extremes, tie on the minimum, fill to full, refused enqueue
    push_item(OP_DEQ, '1);
    push_item(OP_ENQ, 7);
    push_item(OP_ENQ, {1'b1, {(VAL_W-1){1'b0}}});
    push_item(OP_ENQ, {1'b0, {(VAL_W-1){1'b1}}});
    push_item(OP_ENQ, 0);
    push_item(OP_ENQ, -1);
    push_item(OP_ENQ, {1'b1, {(VAL_W-1){1'b0}}});
    push_item(OP_DEQ, 0);
    push_item(OP_DEQ, $urandom);
    push_item(OP_DEQ, $urandom);
    for (k = planned_count; k < CAPACITY; k++) begin
      push_item(OP_ENQ, pick_value());
    end
    push_item(OP_ENQ, 32'h5555_5555);
    push_item(OP_DEQ, $urandom);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      queue_random_walk(WALK_ITEMS);
      wait_until_drained();
    end

    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ump_pkg.sv
rtl/ump_ram.sv
rtl/ump_engine.sv
rtl/unordered_min_priority_queue_top.sv
dv/unordered_min_priority_queue_top_test.sv
